/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros: clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever ante holds in a cycle, cons must hold in the same cycle.
`define ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// expr must never be true.
`define ASSERT_NEVER(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed");

`endif

/* rtl/core/usw_pkg.sv */
// ----------------------------------------------------------------------------
// usw_pkg
// Types and codes shared by the update session window / ack core.
// ----------------------------------------------------------------------------
package usw_pkg;

  // Command codes
  localparam logic [2:0] CMD_BEGIN  = 3'd0;
  localparam logic [2:0] CMD_CHUNK  = 3'd1;
  localparam logic [2:0] CMD_END    = 3'd2;
  localparam logic [2:0] CMD_ABORT  = 3'd3;
  localparam logic [2:0] CMD_TICK   = 3'd4;
  localparam logic [2:0] CMD_VERIFY = 3'd5;

  // Status codes
  localparam logic [3:0] ST_READY         = 4'd0;
  localparam logic [3:0] ST_ACK           = 4'd1;
  localparam logic [3:0] ST_COMMITTING    = 4'd2;
  localparam logic [3:0] ST_REBOOTING     = 4'd3;
  localparam logic [3:0] ST_ABORTED       = 4'd4;
  localparam logic [3:0] ST_VERIFIED      = 4'd5;
  localparam logic [3:0] ST_NOT_PENDING   = 4'd6;
  localparam logic [3:0] ST_BAD_PAYLOAD   = 4'd7;
  localparam logic [3:0] ST_BEGIN_FAILED  = 4'd8;
  localparam logic [3:0] ST_WRITE_FAILED  = 4'd9;
  localparam logic [3:0] ST_SIZE_MISMATCH = 4'd10;
  localparam logic [3:0] ST_END_FAILED    = 4'd11;

  // Register indexes; each register sits at byte address 4 * index
  localparam logic [1:0] REG_ACK_WINDOW = 2'd0;
  localparam logic [1:0] REG_MAX_IMAGE  = 2'd1;
  localparam logic [1:0] REG_WATCHDOG   = 2'd2;

  localparam logic [7:0]  PAYLOAD_LEN_REQ  = 8'd36;
  localparam logic [7:0]  ACK_WINDOW_RST   = 8'd16;
  localparam logic [31:0] MAX_IMAGE_RST    = 32'd3 * 32'd1024 * 32'd1024;
  localparam logic [31:0] WATCHDOG_RST     = 32'd10000;

  typedef struct packed {
    logic [7:0]  ack_window;
    logic [31:0] max_image_size;
    logic [31:0] watchdog_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] image_size;
    logic [7:0]  begin_len;
    logic [15:0] chunk_len;
    logic        lower_ok;
    logic        user_enable;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] byte_count;
    logic        enable_write;
    logic        enable_value;
    logic        last;
  } res_t;

  // Build a result; the enable value reads zero when the line is not driven.
  function automatic res_t mk_res(logic [3:0] st, logic [31:0] bytes, logic we,
                                  logic wv, logic lst);
    res_t r;
    r.status       = st;
    r.byte_count   = bytes;
    r.enable_write = we;
    r.enable_value = we & wv;
    r.last         = lst;
    return r;
  endfunction

endpackage

/* rtl/core/usw_regs.sv */
// ----------------------------------------------------------------------------
// usw_regs
// APB configuration registers: ack window, max image size, watchdog time.
// ----------------------------------------------------------------------------
module usw_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output usw_pkg::cfg_t cfg
);
  import usw_pkg::*;

  logic [1:0] idx;
  logic       wr_en;

  assign idx    = paddr[3:2];
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ack_window     <= ACK_WINDOW_RST;
      cfg.max_image_size <= MAX_IMAGE_RST;
      cfg.watchdog_ms    <= WATCHDOG_RST;
    end else if (wr_en) begin
      case (idx)
        REG_ACK_WINDOW: cfg.ack_window     <= pwdata[7:0];
        REG_MAX_IMAGE:  cfg.max_image_size <= pwdata;
        REG_WATCHDOG:   cfg.watchdog_ms    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ACK_WINDOW: prdata = {24'd0, cfg.ack_window};
      REG_MAX_IMAGE:  prdata = cfg.max_image_size;
      REG_WATCHDOG:   prdata = cfg.watchdog_ms;
      default:        prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/core/usw_cmd.sv */
// ----------------------------------------------------------------------------
// usw_cmd
// Command stage: registered item, session state, and up to two results.
// ----------------------------------------------------------------------------
module usw_cmd (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  usw_pkg::item_t item,
  input  usw_pkg::cfg_t  cfg,
  output logic [1:0]     push_n,
  output usw_pkg::res_t  res0,
  output usw_pkg::res_t  res1
);
  import usw_pkg::*;

  // Committing is only passed through within one command, never held.
  typedef enum logic [3:0] {
    SES_IDLE      = 4'b0001,
    SES_READY     = 4'b0010,
    SES_RECEIVING = 4'b0100,
    SES_REBOOTING = 4'b1000
  } session_t;

  item_t       cur;
  logic        busy;

  session_t    session, session_next;
  logic [31:0] expected_size, expected_size_next;
  logic [31:0] received_bytes, received_bytes_next;
  logic [7:0]  window_count, window_count_next;
  logic        saved_enable, saved_enable_next;
  logic [31:0] last_chunk_time, last_chunk_time_next;
  logic        pending_verify, pending_verify_next;

  logic        active;
  logic        begin_en;
  logic [31:0] recv_sum;
  logic [7:0]  win_inc;
  logic [31:0] idle_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= load;
    end
    if (load) begin
      cur <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      session         <= SES_IDLE;
      expected_size   <= 32'd0;
      received_bytes  <= 32'd0;
      window_count    <= 8'd0;
      saved_enable    <= 1'b0;
      last_chunk_time <= 32'd0;
      pending_verify  <= 1'b0;
    end else begin
      session         <= session_next;
      expected_size   <= expected_size_next;
      received_bytes  <= received_bytes_next;
      window_count    <= window_count_next;
      saved_enable    <= saved_enable_next;
      last_chunk_time <= last_chunk_time_next;
      pending_verify  <= pending_verify_next;
    end
  end

  assign active   = (session == SES_READY) || (session == SES_RECEIVING);
  assign begin_en = active ? saved_enable : cur.user_enable;
  assign recv_sum = received_bytes + {16'd0, cur.chunk_len};
  assign win_inc  = window_count + 8'd1;
  assign idle_ms  = cur.now_ms - last_chunk_time;

  always_comb begin
    session_next         = session;
    expected_size_next   = expected_size;
    received_bytes_next  = received_bytes;
    window_count_next    = window_count;
    saved_enable_next    = saved_enable;
    last_chunk_time_next = last_chunk_time;
    pending_verify_next  = pending_verify;
    push_n               = 2'd0;
    res0                 = mk_res(ST_READY, 32'd0, 1'b0, 1'b0, 1'b1);
    res1                 = mk_res(ST_READY, 32'd0, 1'b0, 1'b0, 1'b1);

    if (busy) begin
      case (cur.cmd)
        CMD_BEGIN: begin
          push_n = 2'd1;
          if (cur.begin_len != PAYLOAD_LEN_REQ) begin
            res0 = mk_res(ST_BAD_PAYLOAD, 32'd0, 1'b0, 1'b0, 1'b1);
          end else begin
            // drop a running session first
            if (active) begin
              session_next        = SES_IDLE;
              expected_size_next  = 32'd0;
              received_bytes_next = 32'd0;
              window_count_next   = 8'd0;
            end
            if (cur.image_size == 32'd0 || cur.image_size > cfg.max_image_size) begin
              res0 = mk_res(ST_BEGIN_FAILED, 32'd0, active, begin_en, 1'b1);
            end else begin
              saved_enable_next   = begin_en;
              received_bytes_next = 32'd0;
              window_count_next   = 8'd0;
              if (!cur.lower_ok) begin
                session_next       = SES_IDLE;
                expected_size_next = 32'd0;
                res0 = mk_res(ST_BEGIN_FAILED, 32'd0, 1'b1, begin_en, 1'b1);
              end else begin
                session_next         = SES_READY;
                expected_size_next   = cur.image_size;
                last_chunk_time_next = cur.now_ms;
                res0 = mk_res(ST_READY, 32'd0, 1'b1, 1'b0, 1'b1);
              end
            end
          end
        end
        CMD_CHUNK: begin
          if (cur.chunk_len != 16'd0 && active) begin
            last_chunk_time_next = cur.now_ms;
            if (!cur.lower_ok) begin
              session_next        = SES_IDLE;
              expected_size_next  = 32'd0;
              received_bytes_next = 32'd0;
              window_count_next   = 8'd0;
              push_n = 2'd1;
              res0 = mk_res(ST_WRITE_FAILED, received_bytes, 1'b1, saved_enable, 1'b1);
            end else begin
              session_next        = SES_RECEIVING;
              received_bytes_next = recv_sum;
              window_count_next   = win_inc;
              if (win_inc >= cfg.ack_window || recv_sum >= expected_size) begin
                window_count_next = 8'd0;
                push_n = 2'd1;
                res0 = mk_res(ST_ACK, recv_sum, 1'b0, 1'b0, 1'b1);
              end
            end
          end
        end
        CMD_END: begin
          push_n = 2'd1;
          if (!active) begin
            res0 = mk_res(ST_END_FAILED, received_bytes, 1'b0, 1'b0, 1'b1);
          end else if (received_bytes != expected_size) begin
            session_next        = SES_IDLE;
            expected_size_next  = 32'd0;
            received_bytes_next = 32'd0;
            window_count_next   = 8'd0;
            res0 = mk_res(ST_SIZE_MISMATCH, received_bytes, 1'b1, saved_enable, 1'b1);
          end else begin
            push_n = 2'd2;
            res0 = mk_res(ST_COMMITTING, received_bytes, 1'b0, 1'b0, 1'b0);
            if (!cur.lower_ok) begin
              session_next        = SES_IDLE;
              expected_size_next  = 32'd0;
              received_bytes_next = 32'd0;
              window_count_next   = 8'd0;
              res1 = mk_res(ST_END_FAILED, received_bytes, 1'b1, saved_enable, 1'b1);
            end else begin
              pending_verify_next = 1'b1;
              session_next        = SES_REBOOTING;
              res1 = mk_res(ST_REBOOTING, received_bytes, 1'b0, 1'b0, 1'b1);
            end
          end
        end
        CMD_ABORT, CMD_TICK: begin
          // tick aborts only on a stalled transfer
          if (cur.cmd == CMD_ABORT ||
              (session == SES_RECEIVING && idle_ms > cfg.watchdog_ms)) begin
            session_next        = SES_IDLE;
            expected_size_next  = 32'd0;
            received_bytes_next = 32'd0;
            window_count_next   = 8'd0;
            push_n = 2'd1;
            res0 = mk_res(ST_ABORTED, 32'd0, active, saved_enable, 1'b1);
          end
        end
        CMD_VERIFY: begin
          push_n = 2'd1;
          if (!pending_verify) begin
            res0 = mk_res(ST_NOT_PENDING, 32'd0, 1'b0, 1'b0, 1'b1);
          end else if (!cur.lower_ok) begin
            res0 = mk_res(ST_END_FAILED, 32'd0, 1'b0, 1'b0, 1'b1);
          end else begin
            pending_verify_next = 1'b0;
            res0 = mk_res(ST_VERIFIED, 32'd0, 1'b0, 1'b0, 1'b1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/usw_outq.sv */
// ----------------------------------------------------------------------------
// usw_outq
// Result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module usw_outq #(
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [1:0]                   push_n,
  input  usw_pkg::res_t                d0,
  input  usw_pkg::res_t                d1,
  input  logic                         pop,
  output usw_pkg::res_t                head,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  import usw_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  res_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W-1:0] wr_ptr1;

  assign wr_ptr1 = wr_ptr + PTR_W'(1);
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= d0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr1] <= d1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

endmodule

/* rtl/core/update_session_window_ack_core.sv */
// ----------------------------------------------------------------------------
// update_session_window_ack_core
// Firmware-update session controller with windowed acks and watchdog abort.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake           | content
//  ---------+-----------+---------------------+------------------------------
//  s_*      | in        | s_tvalid / s_tready | one command per transaction
//  m_*      | out       | m_tvalid / m_tready | zero to two results per command
//  apb      | in        | psel / penable      | ack_window, max_image_size,
//           |           | (pready always 1)   | watchdog_ms at 0x0, 0x4, 0x8
//
//  A command accepted at one edge sits in the command register; session
//  state and results are settled at the next edge, and the results enter
//  the result queue at that edge. One command per cycle is taken while
//  s_tready is high; an end command can yield two results, so the one
//  result per cycle of the output channel sets the rate while ends are
//  frequent. Synchronous reset returns the session to idle and loads
//  register defaults. Backpressure on m_tready fills the result queue and
//  then drops s_tready; no result is lost or reordered.
//
module update_session_window_ack_core #(
  parameter int OUTQ_DEPTH = 4  // power of two, at least 4
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        s_tvalid,
  output logic        s_tready,
  // [31:0] image_size, [39:32] begin_len, [55:40] chunk_len,
  // [56] lower_ok, [57] user_enable, [89:58] now_ms, [95:90] zero
  input  logic [95:0] s_tdata,
  // [2:0] cmd
  input  logic [2:0]  s_tuser,

  output logic        m_tvalid,
  input  logic        m_tready,
  // [31:0] byte_count, [32] enable_write, [33] enable_value, [39:34] zero
  output logic [39:0] m_tdata,
  // [3:0] status
  output logic [3:0]  m_tuser,
  output logic        m_tlast,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import usw_pkg::*;

  localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

  cfg_t             cfg;
  item_t            item;
  logic             accept;
  logic [1:0]       push_n;
  res_t             res0, res1, head;
  logic [CNT_W-1:0] q_count;
  logic [CNT_W:0]   q_need;
  logic             pop;

  // Unpack the command transaction.
  assign item.cmd         = s_tuser;
  assign item.image_size  = s_tdata[31:0];
  assign item.begin_len   = s_tdata[39:32];
  assign item.chunk_len   = s_tdata[55:40];
  assign item.lower_ok    = s_tdata[56];
  assign item.user_enable = s_tdata[57];
  assign item.now_ms      = s_tdata[89:58];

  // Take a new command only if the queue can still absorb two results
  // after what the command register pushes this cycle.
  assign q_need   = {1'b0, q_count} + (CNT_W + 1)'(push_n);
  assign s_tready = q_need <= (CNT_W + 1)'(OUTQ_DEPTH - 2);
  assign accept   = s_tvalid & s_tready;

  usw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  usw_cmd u_cmd (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .item   (item),
    .cfg    (cfg),
    .push_n (push_n),
    .res0   (res0),
    .res1   (res1)
  );

  usw_outq #(
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk    (clk),
    .rst    (rst),
    .push_n (push_n),
    .d0     (res0),
    .d1     (res1),
    .pop    (pop),
    .head   (head),
    .count  (q_count)
  );

  // Drive the result transaction from the queue head.
  assign m_tvalid = q_count != '0;
  assign pop      = m_tvalid & m_tready;
  assign m_tdata  = {6'd0, head.enable_value, head.enable_write, head.byte_count};
  assign m_tuser  = head.status;
  assign m_tlast  = head.last;

`include "assert_macros.svh"

  // The queue never takes more results than it has room for.
  `ASSERT_IMPLIES(a_no_overflow, push_n != 2'd0, q_need <= (CNT_W + 1)'(OUTQ_DEPTH))
  // A command never yields three results.
  `ASSERT_NEVER(a_push_range, push_n == 2'd3)
  // A pair of results is committing then final; only the second closes.
  `ASSERT_IMPLIES(a_pair_last, push_n == 2'd2,
                  !res0.last && res1.last && res0.status == ST_COMMITTING)
  // An undriven enable line always reports a zero value.
  `ASSERT_IMPLIES(a_enable_quiet, m_tvalid && !m_tdata[32], !m_tdata[33])

endmodule
